/* sv/ustc_pkg.sv */
// Shared constants, types and the month start lookup for the Unix time to calendar pipeline.
package ustc_pkg;

    localparam int STAGES = 10;

    localparam int DAYS_W = 16;
    localparam int SOD_W  = 17;
    localparam int SOH_W  = 12;
    localparam int QX_W   = 19;
    localparam int JD_W   = 22;
    localparam int YX_W   = 26;
    localparam int YR_W   = 13;
    localparam int DOY_W  = 9;
    localparam int D4_W   = 17;
    localparam int WQ_W   = 13;

    localparam logic [31:0]      SECS_PER_DAY  = 32'd86400;
    localparam logic [SOD_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [SOH_W-1:0] SECS_PER_MIN  = 12'd60;

    localparam logic [15:0] DAY_RECIP  = 16'((64'd1 << 32) / 64'd86400);
    localparam logic [5:0]  HOUR_RECIP = 6'((64'd1 << SOD_W) / 64'd3600);
    localparam logic [6:0]  MIN_RECIP  = 7'((64'd1 << SOH_W) / 64'd60);
    localparam logic [14:0] WEEK_RECIP = 15'((64'd1 << D4_W) / 64'd7);
    localparam logic [13:0] YEAR_RECIP = 14'((64'd1 << YX_W) / 64'd7305);
    localparam logic [14:0] MON_RECIP  = 15'(((64'd1 << QX_W) / 64'd30601) * 64'd1000);

    localparam logic [QX_W-1:0] CENT_BIAS  = 19'd102032;
    localparam logic [QX_W-1:0] CENT_DAYS  = 19'd146097;
    localparam logic [4:0]      ALPHA_BASE = 5'd15;
    localparam logic [JD_W-1:0] JD_BIAS    = 22'd2442113;
    localparam logic [YX_W-1:0] YX_SCALE   = 26'd20;
    localparam logic [YX_W-1:0] YX_BIAS    = 26'd2442;
    localparam logic [YX_W-1:0] YEAR_SPAN  = 26'd7305;
    localparam logic [JD_W-1:0] DAYS_YEAR  = 22'd365;
    localparam logic [QX_W-1:0] MON_SCALE  = 19'd1000;
    localparam logic [QX_W-1:0] MON_SPAN   = 19'd30601;
    localparam logic [3:0]      MONTH_WRAP = 4'd13;
    localparam logic [YR_W-1:0] YEAR_OFS_A = 13'd4716;
    localparam logic [YR_W-1:0] YEAR_OFS_B = 13'd4715;
    localparam logic [D4_W-1:0] EPOCH_WDAY = 17'd4;
    localparam logic [D4_W-1:0] WEEK_DAYS  = 17'd7;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
    } hms_t;

    typedef struct packed {
        logic [4:0]  dom;
        logic [3:0]  mon;
        logic [11:0] year;
        logic [2:0]  wday;
    } date_t;

    // Day count at which each shifted month starts, floor(30.601 * month).
    function automatic logic [DOY_W-1:0] month_base(input logic [3:0] mon);
        logic [DOY_W-1:0] base;
        unique case (mon)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd30;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd91;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd183;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd244;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd336;
            4'd12:   base = 9'd367;
            4'd13:   base = 9'd397;
            4'd14:   base = 9'd428;
            default: base = 9'd459;
        endcase
        return base;
    endfunction

endpackage

/* sv/ustc_tod.sv */
// Splits the timestamp into a day count and the time of day, then aligns it with the date path.
module ustc_tod
    import ustc_pkg::*;
(
    input  logic                clk,
    input  logic [STAGES-1:0]   en,
    input  logic [31:0]         unix_seconds,
    output logic [DAYS_W-1:0]   days,
    output hms_t                hms
);

    localparam int DELAY = STAGES - 6;

    logic [31:0]       t1_reg;
    logic [DAYS_W-1:0] dq_reg, dq_next;
    logic [47:0]       prod1;

    logic [DAYS_W-1:0] days_reg, days_next;
    logic [SOD_W-1:0]  sod_reg, sod_next;
    logic [31:0]       prod2, r2;

    logic [SOD_W-1:0]  sod3_reg;
    logic [4:0]        hq_reg, hq_next;
    logic [22:0]       prod3;

    logic [4:0]        hour4_reg, hour4_next;
    logic [SOH_W-1:0]  soh_reg, soh_next;
    logic [SOD_W-1:0]  r4;

    logic [4:0]        hour5_reg;
    logic [SOH_W-1:0]  soh5_reg;
    logic [5:0]        mq_reg, mq_next;
    logic [18:0]       prod5;

    hms_t              hms6_reg, hms6_next;
    logic [SOH_W-1:0]  r6;

    hms_t              hms_pipe_reg [DELAY];

    always_comb
    begin
        prod1   = 48'(unix_seconds) * 48'(DAY_RECIP);
        dq_next = prod1[47:32];
    end

    always_comb
    begin
        prod2 = 32'(dq_reg) * SECS_PER_DAY;
        r2    = t1_reg - prod2;
        if (r2 >= SECS_PER_DAY)
        begin
            days_next = dq_reg + 16'd1;
            sod_next  = SOD_W'(r2 - SECS_PER_DAY);
        end
        else
        begin
            days_next = dq_reg;
            sod_next  = SOD_W'(r2);
        end
    end

    always_comb
    begin
        prod3   = 23'(sod_reg) * 23'(HOUR_RECIP);
        hq_next = 5'(prod3[22:SOD_W]);
    end

    always_comb
    begin
        r4 = sod3_reg - SOD_W'(hq_reg) * SECS_PER_HOUR;
        if (r4 >= SECS_PER_HOUR)
        begin
            hour4_next = hq_reg + 5'd1;
            soh_next   = SOH_W'(r4 - SECS_PER_HOUR);
        end
        else
        begin
            hour4_next = hq_reg;
            soh_next   = SOH_W'(r4);
        end
    end

    always_comb
    begin
        prod5   = 19'(soh_reg) * 19'(MIN_RECIP);
        mq_next = 6'(prod5[18:SOH_W]);
    end

    always_comb
    begin
        r6             = soh5_reg - SOH_W'(mq_reg) * SECS_PER_MIN;
        hms6_next.hour = hour5_reg;
        if (r6 >= SECS_PER_MIN)
        begin
            hms6_next.min = mq_reg + 6'd1;
            hms6_next.sec = 6'(r6 - SECS_PER_MIN);
        end
        else
        begin
            hms6_next.min = mq_reg;
            hms6_next.sec = 6'(r6);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg <= unix_seconds;
            dq_reg <= dq_next;
        end
        if (en[1])
        begin
            days_reg <= days_next;
            sod_reg  <= sod_next;
        end
        if (en[2])
        begin
            sod3_reg <= sod_reg;
            hq_reg   <= hq_next;
        end
        if (en[3])
        begin
            hour4_reg <= hour4_next;
            soh_reg   <= soh_next;
        end
        if (en[4])
        begin
            hour5_reg <= hour4_reg;
            soh5_reg  <= soh_reg;
            mq_reg    <= mq_next;
        end
        if (en[5])
        begin
            hms6_reg <= hms6_next;
        end
        if (en[6])
        begin
            hms_pipe_reg[0] <= hms6_reg;
        end
        for (int i = 1; i < DELAY; i++)
        begin
            if (en[6 + i])
            begin
                hms_pipe_reg[i] <= hms_pipe_reg[i - 1];
            end
        end
    end

    assign days = days_reg;
    assign hms  = hms_pipe_reg[DELAY - 1];

endmodule

/* sv/ustc_date.sv */
// Converts the day count into Gregorian year, month, day and weekday over pipeline stages.
module ustc_date
    import ustc_pkg::*;
(
    input  logic                clk,
    input  logic [STAGES-1:0]   en,
    input  logic [DAYS_W-1:0]   days,
    output date_t               date
);

    localparam int WD_DELAY = STAGES - 4;

    logic [QX_W-1:0]  x3;
    logic [1:0]       cent;
    logic [4:0]       alpha, adj;
    logic [JD_W-1:0]  b3_reg, b3_next;
    logic [D4_W-1:0]  d4_reg, d4_next;
    logic [31:0]      prodw;
    logic [WQ_W-1:0]  wq_reg, wq_next;

    logic [YX_W-1:0]  x4, x4_reg;
    logic [39:0]      yprod;
    logic [YR_W-1:0]  yq_reg, yq_next;
    logic [JD_W-1:0]  b4_reg;
    logic [D4_W-1:0]  rw;
    logic [2:0]       wd_next;
    logic [2:0]       wd_pipe_reg [WD_DELAY];

    logic [YX_W-1:0]  r5;
    logic [YR_W-1:0]  yr5_reg, yr5_next;
    logic [JD_W-1:0]  b5_reg;

    logic [DOY_W-1:0] doy6_reg, doy6_next;
    logic [YR_W-1:0]  yr6_reg;

    logic [23:0]      mp;
    logic [3:0]       mq7_reg, mq7_next;
    logic [DOY_W-1:0] doy7_reg;
    logic [YR_W-1:0]  yr7_reg;

    logic [QX_W-1:0]  r8;
    logic [3:0]       mo8_reg, mo8_next;
    logic [DOY_W-1:0] doy8_reg;
    logic [YR_W-1:0]  yr8_reg;

    logic [4:0]       dom9_reg, dom9_next;
    logic [3:0]       mo9_reg;
    logic [YR_W-1:0]  yr9_reg;

    date_t            date_reg, date_next;

    always_comb
    begin
        x3 = QX_W'({days, 2'b00}) + CENT_BIAS;
        if (x3 >= (CENT_DAYS << 1))
        begin
            cent = 2'd2;
        end
        else if (x3 >= CENT_DAYS)
        begin
            cent = 2'd1;
        end
        else
        begin
            cent = 2'd0;
        end
        alpha   = 5'(cent) + ALPHA_BASE;
        adj     = alpha - (alpha >> 2);
        b3_next = JD_W'(days) + JD_BIAS + JD_W'(adj);
        d4_next = D4_W'(days) + EPOCH_WDAY;
        prodw   = 32'(d4_next) * 32'(WEEK_RECIP);
        wq_next = WQ_W'(prodw[31:D4_W]);
    end

    always_comb
    begin
        x4      = b3_reg * YX_SCALE - YX_BIAS;
        yprod   = 40'(x4) * 40'(YEAR_RECIP);
        yq_next = YR_W'(yprod[39:YX_W]);
        rw      = d4_reg - D4_W'(wq_reg) * WEEK_DAYS;
        if (rw >= WEEK_DAYS)
        begin
            wd_next = 3'(rw - WEEK_DAYS) + 3'd1;
        end
        else
        begin
            wd_next = 3'(rw) + 3'd1;
        end
    end

    always_comb
    begin
        r5 = x4_reg - YX_W'(yq_reg) * YEAR_SPAN;
        if (r5 >= YEAR_SPAN)
        begin
            yr5_next = yq_reg + 13'd1;
        end
        else
        begin
            yr5_next = yq_reg;
        end
    end

    always_comb
    begin
        doy6_next = DOY_W'(b5_reg - JD_W'(yr5_reg) * DAYS_YEAR - JD_W'(yr5_reg >> 2));
    end

    always_comb
    begin
        mp       = 24'(doy6_reg) * 24'(MON_RECIP);
        mq7_next = 4'(mp[23:QX_W]);
    end

    always_comb
    begin
        r8 = QX_W'(doy7_reg) * MON_SCALE - QX_W'(mq7_reg) * MON_SPAN;
        if (r8 >= MON_SPAN)
        begin
            mo8_next = mq7_reg + 4'd1;
        end
        else
        begin
            mo8_next = mq7_reg;
        end
    end

    always_comb
    begin
        dom9_next = 5'(doy8_reg - month_base(mo8_reg));
    end

    always_comb
    begin
        date_next.dom  = dom9_reg;
        date_next.wday = wd_pipe_reg[WD_DELAY - 1];
        if (mo9_reg <= MONTH_WRAP)
        begin
            date_next.year = 12'(yr9_reg - YEAR_OFS_A);
            date_next.mon  = mo9_reg - 4'd1;
        end
        else
        begin
            date_next.year = 12'(yr9_reg - YEAR_OFS_B);
            date_next.mon  = mo9_reg - MONTH_WRAP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            b3_reg <= b3_next;
            d4_reg <= d4_next;
            wq_reg <= wq_next;
        end
        if (en[3])
        begin
            x4_reg         <= x4;
            yq_reg         <= yq_next;
            b4_reg         <= b3_reg;
            wd_pipe_reg[0] <= wd_next;
        end
        for (int i = 1; i < WD_DELAY; i++)
        begin
            if (en[3 + i])
            begin
                wd_pipe_reg[i] <= wd_pipe_reg[i - 1];
            end
        end
        if (en[4])
        begin
            yr5_reg <= yr5_next;
            b5_reg  <= b4_reg;
        end
        if (en[5])
        begin
            doy6_reg <= doy6_next;
            yr6_reg  <= yr5_reg;
        end
        if (en[6])
        begin
            mq7_reg  <= mq7_next;
            doy7_reg <= doy6_reg;
            yr7_reg  <= yr6_reg;
        end
        if (en[7])
        begin
            mo8_reg  <= mo8_next;
            doy8_reg <= doy7_reg;
            yr8_reg  <= yr7_reg;
        end
        if (en[8])
        begin
            dom9_reg <= dom9_next;
            mo9_reg  <= mo8_reg;
            yr9_reg  <= yr8_reg;
        end
        if (en[9])
        begin
            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

/* sv/unix_seconds_to_calendar.sv */
// Top level of the Unix seconds to calendar date and time converter.
// The converter is a ten-stage pipeline that takes one request per clock cycle while the output
// is not stalled, and returns each result from its last stage.
// The depth is set by the chain of reciprocal multiply and correct steps for the day,
// hour, minute, year and month divisions, each one multiply wide followed by a register.
// Every stage carries a valid bit and loads when it is empty or when the stage after it can
// take its contents, so a stall on the result side fills empty stages before it reaches the
// request side, and no request is lost or repeated.
module unix_seconds_to_calendar
    import ustc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        request_valid,
    output logic        request_stall,
    input  logic [31:0] unix_seconds,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [11:0] year_number,
    output logic [2:0]  weekday
);

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] adv;
    logic [DAYS_W-1:0] days;
    hms_t              hms;
    date_t             date;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k + 1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? request_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k - 1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    ustc_tod u_tod
    (
        .clk          (clk),
        .en           (adv),
        .unix_seconds (unix_seconds),
        .days         (days),
        .hms          (hms)
    );

    ustc_date u_date
    (
        .clk  (clk),
        .en   (adv),
        .days (days),
        .date (date)
    );

    assign request_stall = !adv[0];
    assign result_valid  = valid_reg[STAGES-1];
    assign second        = hms.sec;
    assign minute        = hms.min;
    assign hour          = hms.hour;
    assign day_of_month  = date.dom;
    assign month_number  = date.mon;
    assign year_number   = date.year;
    assign weekday       = date.wday;

endmodule

/* sv/ustc_checker.sv */
// Port-level checks for the Unix seconds to calendar converter and their attachment.
module ustc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        request_valid,
    input logic        request_stall,
    input logic [31:0] unix_seconds,
    input logic        result_valid,
    input logic        result_stall,
    input logic [5:0]  second,
    input logic [5:0]  minute,
    input logic [4:0]  hour,
    input logic [4:0]  day_of_month,
    input logic [3:0]  month_number,
    input logic [11:0] year_number,
    input logic [2:0]  weekday
);

    // A stalled result stays on the port.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(second) && $stable(minute) && $stable(hour)
            && $stable(day_of_month) && $stable(month_number) && $stable(year_number)
            && $stable(weekday))
        else $error("result changed while stalled");

    // With no result waiting, every stage can move, so requests are never stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !request_stall)
        else $error("request stalled with an empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> second < 6'd60 && minute < 6'd60 && hour < 5'd24)
        else $error("time of day out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> day_of_month != 5'd0 && month_number != 4'd0
            && month_number < 4'd13 && weekday != 3'd0
            && year_number >= 12'd1970 && year_number <= 12'd2106)
        else $error("calendar date out of range");

endmodule

bind unix_seconds_to_calendar ustc_checker u_ustc_checker (.*);
